[hw/rtl/at_rlp_pkg.sv]
// Shared types, codes and result-string tables for the AT response line parser.
package at_rlp_pkg;

  localparam int unsigned NumCodes = 8;
  localparam int unsigned TextLen  = 11;

  // Item opcodes.
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  // Result codes.
  localparam logic [3:0] RC_NONE    = 4'd0;
  localparam logic [3:0] RC_OK      = 4'd1;
  localparam logic [3:0] RC_ERROR   = 4'd2;
  localparam logic [3:0] RC_CME     = 4'd8;
  localparam logic [3:0] RC_UNKNOWN = 4'd9;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [15:0] INTEROCTET_RESET = 16'd100;

  // Register index of the inter-octet limit.
  localparam logic REG_INTEROCTET = 1'b0;

  typedef enum logic [1:0] {
    PH_HDR_CR  = 2'd0,
    PH_HDR_LF  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRL_LF  = 2'd3
  } phase_e;

  // Result strings, padded with spaces to a common length; first char leftmost.
  localparam logic [8*TextLen-1:0] CODE_TEXT [NumCodes] = '{
    "OK         ",
    "ERROR      ",
    "NO CARRIER ",
    "NO ANSWER  ",
    "NO DIALTONE",
    "BUSY       ",
    "RING       ",
    "+CME ERROR "
  };

  localparam logic [3:0] CODE_LEN [NumCodes] = '{
    4'd2, 4'd5, 4'd10, 4'd9, 4'd11, 4'd4, 4'd4, 4'd10
  };

  typedef struct packed {
    logic [1:0] status;
    logic       line_done;
    logic [3:0] result_code;
    logic       was_solicited;
    logic [1:0] timeout_flags;
    logic       cmd_busy;
    logic [4:0] body_length;
  } result_t;

  // Character at position pos of result string k (pos below the string length).
  function automatic logic [7:0] code_char(input logic [2:0] k, input logic [3:0] pos);
    logic [3:0]             idx;
    logic [8*TextLen-1:0]   txt;
    idx = 4'd10 - pos;
    txt = CODE_TEXT[k];
    return txt[{idx, 3'b000} +: 8];
  endfunction

endpackage

[hw/rtl/at_rlp_core.sv]
// Parser state, framing, string matching and timers for one word per cycle while fire_i is high.
module at_rlp_core import at_rlp_pkg::*; #(
  parameter int unsigned BODY_MAX = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] cmd_timeout_i,
  input  logic [15:0] octet_limit_i,
  output result_t     result_o
);

  localparam int unsigned CntW = $clog2(BODY_MAX + 1);
  localparam int unsigned CmpW = CntW + 4;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] body_cnt_q, body_cnt_d;
  logic [7:0]      match_q, match_d;
  logic            busy_q, busy_d;
  logic            oct_run_q, oct_run_d;
  logic [15:0]     oct_cnt_q, oct_cnt_d;
  logic            cmd_run_q, cmd_run_d;
  logic [15:0]     cmd_cnt_q, cmd_cnt_d;
  logic [15:0]     cmd_limit_q, cmd_limit_d;

  logic [7:0]      match_upd;
  logic [3:0]      class_code;
  logic [15:0]     oct_inc, cmd_inc;
  logic            oct_abort, cmd_abort;
  logic [CntW+4:0] body_ext;

  // Running match: a string stays live while each body char equals its text.
  always_comb begin
    for (int i = 0; i < NumCodes; i++) begin
      match_upd[i] = match_q[i]
                   && (CmpW'(body_cnt_q) < CmpW'(CODE_LEN[i]))
                   && (code_char(3'(i), body_cnt_q[3:0]) == rx_byte_i);
    end
  end

  // First live string whose length equals the body length wins.
  always_comb begin
    class_code = RC_UNKNOWN;
    for (int i = NumCodes - 1; i >= 0; i--) begin
      if (match_q[i] && (CmpW'(body_cnt_q) == CmpW'(CODE_LEN[i]))) begin
        class_code = 4'(i + 1);
      end
    end
  end

  assign oct_inc   = (oct_run_q && oct_cnt_q != 16'hFFFF) ? oct_cnt_q + 16'd1 : oct_cnt_q;
  assign cmd_inc   = (cmd_run_q && cmd_cnt_q != 16'hFFFF) ? cmd_cnt_q + 16'd1 : cmd_cnt_q;
  assign oct_abort = oct_run_q && (oct_inc > octet_limit_i);
  // The inter-octet abort stops the command timer, so it masks this check.
  assign cmd_abort = !oct_abort && (cmd_limit_q != 16'd0) && cmd_run_q
                   && (cmd_inc > cmd_limit_q);

  always_comb begin
    phase_d     = phase_q;
    body_cnt_d  = body_cnt_q;
    match_d     = match_q;
    busy_d      = busy_q;
    oct_run_d   = oct_run_q;
    oct_cnt_d   = oct_cnt_q;
    cmd_run_d   = cmd_run_q;
    cmd_cnt_d   = cmd_cnt_q;
    cmd_limit_d = cmd_limit_q;
    result_o    = '0;

    unique case (opcode_i)
      OP_BYTE: begin
        oct_run_d = 1'b1;
        oct_cnt_d = 16'd0;
        unique case (phase_q)
          PH_HDR_CR: begin
            if (rx_byte_i == CHAR_CR) begin
              body_cnt_d = '0;
              match_d    = 8'hFF;
              phase_d    = PH_HDR_LF;
            end else begin
              result_o.status = ST_FRAME;
            end
          end
          PH_HDR_LF: begin
            if (rx_byte_i == CHAR_LF) phase_d = PH_BODY;
            else result_o.status = ST_FRAME;
          end
          PH_BODY: begin
            if (rx_byte_i == CHAR_CR) begin
              phase_d = PH_TRL_LF;
            end else if (rx_byte_i == CHAR_LF) begin
              result_o.status = ST_FRAME;
            end else if (body_cnt_q < CntW'(BODY_MAX)) begin
              match_d    = match_upd;
              body_cnt_d = body_cnt_q + 1'b1;
            end else begin
              result_o.status = ST_FULL;
            end
          end
          PH_TRL_LF: begin
            if (rx_byte_i == CHAR_LF) begin
              oct_run_d              = 1'b0;
              phase_d                = PH_HDR_CR;
              result_o.line_done     = 1'b1;
              result_o.result_code   = class_code;
              result_o.was_solicited = busy_q;
              if (class_code == RC_OK || class_code == RC_ERROR || class_code == RC_CME) begin
                busy_d    = 1'b0;
                cmd_run_d = 1'b0;
                cmd_cnt_d = 16'd0;
              end
            end else begin
              result_o.status = ST_FRAME;
            end
          end
          default: ;
        endcase
      end
      OP_CMD: begin
        if (busy_q) begin
          result_o.status = ST_BUSY;
        end else begin
          busy_d      = 1'b1;
          cmd_limit_d = cmd_timeout_i;
          cmd_cnt_d   = 16'd0;
          cmd_run_d   = (cmd_timeout_i != 16'd0);
        end
      end
      OP_TICK: begin
        oct_cnt_d = oct_inc;
        cmd_cnt_d = cmd_inc;
        if (oct_abort || cmd_abort) begin
          oct_run_d = 1'b0;
          oct_cnt_d = 16'd0;
          cmd_run_d = 1'b0;
          cmd_cnt_d = 16'd0;
          phase_d   = PH_HDR_CR;
          busy_d    = 1'b0;
        end
        result_o.timeout_flags = {cmd_abort, oct_abort};
      end
      OP_ABORT: begin
        oct_run_d = 1'b0;
        oct_cnt_d = 16'd0;
        cmd_run_d = 1'b0;
        cmd_cnt_d = 16'd0;
        phase_d   = PH_HDR_CR;
        busy_d    = 1'b0;
      end
      default: ;
    endcase

    result_o.cmd_busy = busy_d;
    body_ext          = (CntW + 5)'(body_cnt_d);
    result_o.body_length = body_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR_CR;
      body_cnt_q  <= '0;
      match_q     <= 8'hFF;
      busy_q      <= 1'b0;
      oct_run_q   <= 1'b0;
      oct_cnt_q   <= 16'd0;
      cmd_run_q   <= 1'b0;
      cmd_cnt_q   <= 16'd0;
      cmd_limit_q <= 16'd0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      body_cnt_q  <= body_cnt_d;
      match_q     <= match_d;
      busy_q      <= busy_d;
      oct_run_q   <= oct_run_d;
      oct_cnt_q   <= oct_cnt_d;
      cmd_run_q   <= cmd_run_d;
      cmd_cnt_q   <= cmd_cnt_d;
      cmd_limit_q <= cmd_limit_d;
    end
  end

  // A stopped timer always holds zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !oct_run_q |-> oct_cnt_q == 16'd0)
    else $error("inter-octet timer stopped with nonzero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !cmd_run_q |-> cmd_cnt_q == 16'd0)
    else $error("command timer stopped with nonzero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      fire_i && opcode_i == OP_ABORT |=> !busy_q && phase_q == PH_HDR_CR && !cmd_run_q)
    else $error("abort did not clear parser state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      body_cnt_q <= CntW'(BODY_MAX))
    else $error("body count beyond buffer limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      fire_i && result_o.line_done |=> phase_q == PH_HDR_CR && !oct_run_q)
    else $error("completed line left parser mid-frame");

endmodule

[hw/rtl/at_response_line_parser_unit.sv]
// Top level of the AT response line parser: handshakes, input and result registers, APB.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | in_valid_i/ready_o  | opcode_i, rx_byte_i, cmd_timeout_i
//  out     | output    | out_valid_o/ready_i | status_o .. body_length_o (one per input)
//  apb     | input     | psel/penable/pready | interoctet_limit at address 0
//
// A word waits in the input register and is then processed into the result register;
// one word is taken per cycle while the output does not stall.
// The parser state is updated at the same edge the result register loads.
// A stalled output holds both registers; in_ready_o then drops once the input register is full.
// Reset clears all control state and sets the inter-octet limit to 100 ms.
module at_response_line_parser_unit import at_rlp_pkg::*; #(
  parameter int unsigned BODY_MAX = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] cmd_timeout_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        line_done_o,
  output logic [3:0]  result_code_o,
  output logic        was_solicited_o,
  output logic [1:0]  timeout_flags_o,
  output logic        cmd_busy_o,
  output logic [4:0]  body_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q;
  logic [1:0]  opcode_q;
  logic [7:0]  rx_byte_q;
  logic [15:0] cmd_timeout_q;
  logic        out_valid_q;
  result_t     out_q, core_res;
  logic [15:0] limit_q;
  logic        out_free, fire, in_fire, cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == REG_INTEROCTET) ? {16'd0, limit_q} : 32'd0;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= INTEROCTET_RESET;
    end else if (cfg_wr && paddr[2] == REG_INTEROCTET) begin
      limit_q <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      opcode_q      <= opcode_i;
      rx_byte_q     <= rx_byte_i;
      cmd_timeout_q <= cmd_timeout_i;
    end
    if (fire) out_q <= core_res;
  end

  at_rlp_core #(
    .BODY_MAX(BODY_MAX)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .opcode_i     (opcode_q),
    .rx_byte_i    (rx_byte_q),
    .cmd_timeout_i(cmd_timeout_q),
    .octet_limit_i(limit_q),
    .result_o     (core_res)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign line_done_o     = out_q.line_done;
  assign result_code_o   = out_q.result_code;
  assign was_solicited_o = out_q.was_solicited;
  assign timeout_flags_o = out_q.timeout_flags;
  assign cmd_busy_o      = out_q.cmd_busy;
  assign body_length_o   = out_q.body_length;

  // A word waiting in the input register is never dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_q && !out_free |=> in_valid_q)
    else $error("input word lost during output stall");
  // Every processed word appears at the output on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> out_valid_q)
    else $error("processed word did not reach the result register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.line_done |-> out_q.result_code != RC_NONE)
    else $error("completed line without a result code");

endmodule

[tb/at_rlp_word_check.sv]
// Result checker for the AT response line parser: predicts every result word and compares it.
module at_rlp_word_check import at_rlp_pkg::*; #(
  parameter int unsigned BODY_MAX = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] cmd_timeout_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic        line_done_i,
  input  logic [3:0]  result_code_i,
  input  logic        was_solicited_i,
  input  logic [1:0]  timeout_flags_i,
  input  logic        cmd_busy_i,
  input  logic [4:0]  body_length_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned fail_count_o
);

  localparam logic [2:0] ADDR_INTEROCTET = {REG_INTEROCTET, 2'b00};
  localparam int TO_OCTET = 0;
  localparam int TO_CMD   = 1;

  string       result_text [NumCodes];
  logic [15:0] octet_limit = INTEROCTET_RESET;
  phase_e      phase = PH_HDR_CR;
  int unsigned body_cnt = 0;
  logic [7:0]  match_flags = 8'hFF;
  logic        busy = 1'b0;
  logic        octet_run = 1'b0;
  logic        cmd_run = 1'b0;
  logic [15:0] octet_cnt = '0;
  logic [15:0] cmd_cnt = '0;
  logic [15:0] cmd_lim = '0;
  result_t     expected_words [$];
  int unsigned fail_total = 0;
  int unsigned checked_total = 0;

  assign fail_count_o = fail_total;

  initial begin
    result_text[0] = "OK";
    result_text[1] = "ERROR";
    result_text[2] = "NO CARRIER";
    result_text[3] = "NO ANSWER";
    result_text[4] = "NO DIALTONE";
    result_text[5] = "BUSY";
    result_text[6] = "RING";
    result_text[7] = "+CME ERROR";
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d %s got %0d, expected %0d",
                                checked_total, name, got, want));
    end
  endtask

  // Both the abort word and either timer expiry end the pending response this way.
  function automatic void stop_all();
    octet_run = 1'b0;
    octet_cnt = '0;
    cmd_run   = 1'b0;
    cmd_cnt   = '0;
    phase     = PH_HDR_CR;
    busy      = 1'b0;
  endfunction

  function automatic result_t parse_word(input logic [1:0] op, input logic [7:0] ch,
                                         input logic [15:0] tmo);
    result_t    r;
    int         k;
    logic [3:0] code;
    r = '0;
    case (op)
      OP_BYTE: begin
        octet_run = 1'b1;
        octet_cnt = '0;
        case (phase)
          PH_HDR_CR: begin
            if (ch == CHAR_CR) begin
              body_cnt    = 0;
              match_flags = 8'hFF;
              phase       = PH_HDR_LF;
            end else begin
              r.status = ST_FRAME;
            end
          end
          PH_HDR_LF: begin
            if (ch == CHAR_LF) phase = PH_BODY;
            else r.status = ST_FRAME;
          end
          PH_BODY: begin
            if (ch == CHAR_CR) begin
              phase = PH_TRL_LF;
            end else if (ch == CHAR_LF) begin
              r.status = ST_FRAME;
            end else if (body_cnt < BODY_MAX) begin
              for (k = 0; k < NumCodes; k++) begin
                if (body_cnt >= result_text[k].len() || result_text[k][body_cnt] != ch) begin
                  match_flags[k] = 1'b0;
                end
              end
              body_cnt++;
            end else begin
              r.status = ST_FULL;
            end
          end
          default: begin
            if (ch == CHAR_LF) begin
              octet_run = 1'b0;
              octet_cnt = '0;
              phase     = PH_HDR_CR;
              // The lowest-numbered string that still matches at full length wins.
              code = RC_UNKNOWN;
              for (k = NumCodes - 1; k >= 0; k--) begin
                if (match_flags[k] && body_cnt == result_text[k].len()) code = 4'(k + 1);
              end
              r.line_done     = 1'b1;
              r.result_code   = code;
              r.was_solicited = busy;
              if (code == RC_OK || code == RC_ERROR || code == RC_CME) begin
                busy    = 1'b0;
                cmd_run = 1'b0;
                cmd_cnt = '0;
              end
            end else begin
              r.status = ST_FRAME;
            end
          end
        endcase
      end
      OP_CMD: begin
        if (busy) begin
          r.status = ST_BUSY;
        end else begin
          busy    = 1'b1;
          cmd_lim = tmo;
          cmd_cnt = '0;
          cmd_run = (tmo != 0);
        end
      end
      OP_TICK: begin
        if (octet_run && octet_cnt != 16'hFFFF) octet_cnt++;
        if (cmd_run && cmd_cnt != 16'hFFFF) cmd_cnt++;
        if (octet_run && octet_cnt > octet_limit) begin
          stop_all();
          r.timeout_flags[TO_OCTET] = 1'b1;
        end
        if (cmd_lim != 0 && cmd_run && cmd_cnt > cmd_lim) begin
          stop_all();
          r.timeout_flags[TO_CMD] = 1'b1;
        end
      end
      default: stop_all();
    endcase
    r.cmd_busy    = busy;
    r.body_length = 5'(body_cnt);
    return r;
  endfunction

  // The pending and checked counts toward the stimulus side change by nonblocking assignment, so the
  // stimulus always sees the values from before the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      octet_limit = INTEROCTET_RESET;
      phase       = PH_HDR_CR;
      body_cnt    = 0;
      match_flags = 8'hFF;
      busy        = 1'b0;
      octet_run   = 1'b0;
      octet_cnt   = '0;
      cmd_run     = 1'b0;
      cmd_cnt     = '0;
      cmd_lim     = '0;
      expected_words.delete();
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with no word outstanding",
                                    checked_total));
        end else begin
          want = expected_words.pop_front();
          check_field("status", status_i, want.status);
          check_field("line_done", line_done_i, want.line_done);
          check_field("result_code", result_code_i, want.result_code);
          check_field("was_solicited", was_solicited_i, want.was_solicited);
          check_field("timeout_flags", timeout_flags_i, want.timeout_flags);
          check_field("cmd_busy", cmd_busy_i, want.cmd_busy);
          check_field("body_length", body_length_i, want.body_length);
        end
        checked_total++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_words.push_back(parse_word(opcode_i, rx_byte_i, cmd_timeout_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_INTEROCTET) begin
        octet_limit = pwdata_i[15:0];
      end
      pending_o <= expected_words.size();
      checked_o <= checked_total;
    end
  end

endmodule

[tb/at_response_line_parser_unit_test.sv]
// Stimulus and verdict for the AT response line parser, checked by at_rlp_word_check.
module at_response_line_parser_unit_test;
  import at_rlp_pkg::*;

  localparam int unsigned BodyMax     = 31;
  localparam int unsigned PhaseWords  = 30;
  localparam int unsigned NumSettings = 6;
  localparam logic [2:0]  ADDR_INTEROCTET = {REG_INTEROCTET, 2'b00};
  localparam logic [2:0]  ADDR_SPARE      = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [7:0]  rx_byte_i;
  logic [15:0] cmd_timeout_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic        line_done_o;
  logic [3:0]  result_code_o;
  logic        was_solicited_o;
  logic [1:0]  timeout_flags_o;
  logic        cmd_busy_o;
  logic [4:0]  body_length_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned fail_words;
  int unsigned words_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned settings_used = 0;
  bit          idle_on = 1'b1;
  string       known_text [NumCodes];

  at_response_line_parser_unit #(
    .BODY_MAX(BodyMax)
  ) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .rx_byte_i, .cmd_timeout_i,
    .out_valid_o, .out_ready_i, .status_o, .line_done_o, .result_code_o,
    .was_solicited_o, .timeout_flags_o, .cmd_busy_o, .body_length_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  at_rlp_word_check #(
    .BODY_MAX(BodyMax)
  ) u_word_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .rx_byte_i, .cmd_timeout_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .line_done_i(line_done_o), .result_code_i(result_code_o),
    .was_solicited_i(was_solicited_o), .timeout_flags_i(timeout_flags_o),
    .cmd_busy_i(cmd_busy_o), .body_length_i(body_length_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .pending_o(pending_words), .checked_o(checked_words), .fail_count_o(fail_words)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("at_response_line_parser_unit verification failed");
    $finish;
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] ch, input logic [15:0] tmo);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    rx_byte_i     <= ch;
    cmd_timeout_i <= tmo;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_word(OP_BYTE, ch, 16'($urandom));
  endtask

  // Sends CR LF body CR LF; a broken line gets one random byte slipped in somewhere.
  task automatic send_line(input string body, input bit broken);
    int spot;
    int i;
    spot = broken ? $urandom_range(0, body.len() + 3) : -1;
    for (i = 0; i < body.len() + 4; i++) begin
      if (i == spot) send_byte(8'($urandom_range(0, 255)));
      if (i == 0 || i == body.len() + 2) send_byte(CHAR_CR);
      else if (i == 1 || i == body.len() + 3) send_byte(CHAR_LF);
      else send_byte(body[i - 2]);
    end
    lines_sent++;
  endtask

  // Every write drops psel and penable again before it returns, so back-to-back writes never overlap.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the sender off until every outstanding word has returned and the pipe is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic string make_text(input int unsigned len);
    string       s;
    int unsigned i;
    s = "";
    for (i = 0; i < len; i++) s = $sformatf("%s%c", s, 8'($urandom_range(32, 126)));
    return s;
  endfunction

  function automatic string pick_body();
    int unsigned roll;
    string       s;
    roll = $urandom_range(0, 99);
    s    = known_text[$urandom_range(0, NumCodes - 1)];
    if (roll < 60) return s;
    if (roll < 70) return "";
    if (roll < 80) return make_text($urandom_range(1, 8));
    if (roll < 85) return s.substr(0, s.len() - 2);
    if (roll < 90) return $sformatf("%s%c", s, 8'($urandom_range(32, 126)));
    return make_text($urandom_range(BodyMax - 2, BodyMax + 5));
  endfunction

  function automatic logic [15:0] pick_timeout();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    if (roll == 2) return 16'($urandom);
    return 16'($urandom_range(1, 12));
  endfunction

  // Result side: a random stall before each word, unless idling is switched off.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [15:0] limit_plan [NumSettings];
    int unsigned p;
    int unsigned phase_end;
    int unsigned roll;
    known_text[0] = "OK";
    known_text[1] = "ERROR";
    known_text[2] = "NO CARRIER";
    known_text[3] = "NO ANSWER";
    known_text[4] = "NO DIALTONE";
    known_text[5] = "BUSY";
    known_text[6] = "RING";
    known_text[7] = "+CME ERROR";
    limit_plan[0] = INTEROCTET_RESET;
    limit_plan[1] = 16'd0;
    limit_plan[2] = 16'd3;
    limit_plan[3] = 16'hFFFF;
    limit_plan[4] = 16'd1;
    limit_plan[5] = 16'($urandom_range(2, 40));
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_BYTE;
    rx_byte_i     = '0;
    cmd_timeout_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: idle tick, zero timeout command, refused command, framing
    // errors in every phase, an OK line that releases the command, abort.
    send_word(OP_TICK, 8'h00, 16'h0000);
    send_word(OP_CMD, 8'hFF, 16'd0);
    send_word(OP_CMD, 8'h00, 16'd5);
    send_byte("A");
    send_byte(8'h00);
    send_byte(CHAR_CR);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    send_byte("O");
    send_byte("K");
    send_byte(CHAR_CR);
    send_byte("Z");
    send_byte(CHAR_LF);
    send_word(OP_CMD, 8'h55, 16'hFFFF);
    send_word(OP_TICK, 8'hAA, 16'hFFFF);
    send_word(OP_TICK, 8'h00, 16'h0000);
    send_word(OP_ABORT, 8'hFF, 16'hFFFF);
    send_word(OP_TICK, 8'h00, 16'h0000);

    for (p = 0; p < NumSettings; p++) begin
      settle();
      idle_on = (p != 2) && ($urandom_range(0, 4) != 0 || p == 0);
      if (p == 1) apb_write(ADDR_SPARE, $urandom);
      if (p > 0) apb_write(ADDR_INTEROCTET, {16'($urandom), limit_plan[p]});
      settings_used++;
      // Every setting starts with one line that overflows the body buffer.
      send_line(make_text(BodyMax + 3), 1'b0);
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          send_line(pick_body(), $urandom_range(0, 9) == 0);
        end else if (roll < 60) begin
          send_word(OP_CMD, 8'($urandom), pick_timeout());
        end else if (roll < 82) begin
          repeat ($urandom_range(1, 6)) send_word(OP_TICK, 8'($urandom), 16'($urandom));
        end else if (roll < 87) begin
          send_word(OP_ABORT, 8'($urandom), 16'($urandom));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Summary: %0d words sent, %0d framed lines, %0d inter-octet limit settings,",
             words_sent, lines_sent, settings_used);
    $display("Summary: %0d result words compared, %0d mismatches.", checked_words, fail_words);
    if (fail_words == 0) begin
      $display("at_response_line_parser_unit verification clean");
    end else begin
      $display("at_response_line_parser_unit verification failed");
    end
    $finish;
  end

endmodule
